// ----- src/assert_macros.svh -----
// Assertion macros used by the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- src/bb5_pkg.sv -----
// Types and constants of the 5x5 box blur.
package bb5_pkg;

   localparam int WIN         = 5;
   localparam int HIST_ROWS   = 4;
   localparam int CHANNELS    = 3;
   localparam int PIX_W       = 8;
   localparam int COLSUM_W    = 11;   // five 8-bit samples
   localparam int WINSUM_W    = 13;   // 25 samples plus the rounding bias
   localparam int PROD_W      = 26;
   localparam int ROUND_BIAS  = 12;
   // Reciprocal of 25 scaled by 2^17; exact for every window sum that can occur.
   localparam int RECIP       = 5243;
   localparam int RECIP_SHIFT = 17;
   localparam int FW_BITS     = 12;
   localparam int FH_BITS     = 13;
   localparam int CSR_W       = 13;
   localparam int MIN_SIZE    = 5;
   localparam int FW_RESET    = 640;
   localparam int FH_RESET    = 480;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_AW     = 3;
   localparam int FIFO_CW     = 4;

   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_reg_type;

   typedef logic [PIX_W-1:0] chan_type;
   typedef chan_type [CHANNELS-1:0] rgb_type;       // [0] blue, [1] green, [2] red
   typedef rgb_type [HIST_ROWS-1:0] hist_type;      // [3] is the most recent row
   typedef logic [COLSUM_W-1:0] colsum_type;
   typedef colsum_type [CHANNELS-1:0] colsum_rgb_type;

   typedef struct packed {
      logic    eof;
      rgb_type mean;
   } result_type;

   typedef struct packed {
      logic [FIFO_CW-1:0] count;
      logic               not_empty;
   } fifo_status_type;

endpackage

// ----- src/bb5_line_ram.sv -----
// Line history memory: one word per column holding the last four rows.
module bb5_line_ram #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output bb5_pkg::hist_type   rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  bb5_pkg::hist_type   wr_data
);

   bb5_pkg::hist_type mem [DEPTH];
   bb5_pkg::hist_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/bb5_out_fifo.sv -----
// Result queue that decouples the pipeline from the output handshake.
module bb5_out_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  bb5_pkg::result_type      push_data,
   input  logic                     pop,
   output bb5_pkg::result_type      pop_data,
   output bb5_pkg::fifo_status_type status
);

   bb5_pkg::result_type              entry_ff [bb5_pkg::FIFO_DEPTH];
   logic [bb5_pkg::FIFO_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [bb5_pkg::FIFO_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [bb5_pkg::FIFO_CW-1:0]      count_ff, count_in;
   logic                             do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + bb5_pkg::FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + bb5_pkg::FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + bb5_pkg::FIFO_CW'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - bb5_pkg::FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data         = entry_ff[rd_ptr_ff];
   assign status.count     = count_ff;
   assign status.not_empty = (count_ff != '0);

endmodule

// ----- src/box_blur_5x5_rgb.sv -----
// Top level of the 5x5 box blur over a raster stream of BGR pixels.
//
//   channel  direction  payload                                  end marker
//   req      in         pixel_blue, pixel_green, pixel_red       none
//   rsp      out        mean_blue, mean_green, mean_red          tlast = end_of_frame
//   csr      in         frame_width (index 0), frame_height (1)  write only
//
// One pixel is taken per clock while req_tready is high; the line memory is read at
// acceptance and written back in the cycle after, so each column address is touched
// once per item. Each result passes s1 to s4, then waits in the queue for the output.
// Input ready drops only when the eight-entry result queue plus in-flight items fill it.
// Reset is synchronous; the line memory is not cleared and needs no sweep.
module box_blur_5x5_rgb #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,   // pixel_blue, pixel_green, pixel_red
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,   // mean_blue, mean_green, mean_red
   output logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [0:0]                     csr_index,
   input  logic [bb5_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int CB = $clog2(MAX_WIDTH);
   localparam int RB = $clog2(MAX_HEIGHT);
   localparam int WB = $clog2(MAX_WIDTH + 1);
   localparam int HB = $clog2(MAX_HEIGHT + 1);
   localparam int EW = (WB > bb5_pkg::FW_BITS) ? WB : bb5_pkg::FW_BITS;
   localparam int EH = (HB > bb5_pkg::FH_BITS) ? HB : bb5_pkg::FH_BITS;

   logic [bb5_pkg::FW_BITS-1:0] frame_width_ff;
   logic [bb5_pkg::FH_BITS-1:0] frame_height_ff;
   logic [CB-1:0]               col_ff, col_in;
   logic [RB-1:0]               row_ff, row_in;

   logic [EW-1:0] fw_ext, w_eff, col_p1;
   logic [EH-1:0] fh_ext, h_eff, row_p1;
   logic          last_col, last_row, emit, accept;

   logic                        s1_valid_ff, s1_emit_ff, s1_eof_ff;
   logic [CB-1:0]               s1_addr_ff;
   bb5_pkg::rgb_type            s1_pix_ff;
   bb5_pkg::hist_type           hist_rd, hist_wr;
   bb5_pkg::colsum_rgb_type     col_sums_ff [bb5_pkg::WIN];
   bb5_pkg::colsum_rgb_type     new_colsum;

   logic                        s2_emit_ff, s2_eof_ff;
   logic [bb5_pkg::WINSUM_W-1:0] win_sum [bb5_pkg::CHANNELS];
   logic                        s3_emit_ff, s3_eof_ff;
   logic [bb5_pkg::WINSUM_W-1:0] s3_sum_ff [bb5_pkg::CHANNELS];
   logic                        s4_emit_ff, s4_eof_ff;
   logic [bb5_pkg::PROD_W-1:0]  s4_prod_ff [bb5_pkg::CHANNELS];

   bb5_pkg::result_type         push_data, pop_data;
   bb5_pkg::fifo_status_type    fifo_status;
   logic [bb5_pkg::FIFO_CW:0]   committed;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bb5_pkg::FW_BITS'(bb5_pkg::FW_RESET);
         frame_height_ff <= bb5_pkg::FH_BITS'(bb5_pkg::FH_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            bb5_pkg::REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata[bb5_pkg::FW_BITS-1:0];
            end
            bb5_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata[bb5_pkg::FH_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Effective frame size, clamped to the supported range.
   always_comb begin
      fw_ext = EW'(frame_width_ff);
      fh_ext = EH'(frame_height_ff);
      if (fw_ext < EW'(bb5_pkg::MIN_SIZE)) begin
         w_eff = EW'(bb5_pkg::MIN_SIZE);
      end else if (fw_ext > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = fw_ext;
      end
      if (fh_ext < EH'(bb5_pkg::MIN_SIZE)) begin
         h_eff = EH'(bb5_pkg::MIN_SIZE);
      end else if (fh_ext > EH'(MAX_HEIGHT)) begin
         h_eff = EH'(MAX_HEIGHT);
      end else begin
         h_eff = fh_ext;
      end
   end

   assign col_p1   = EW'(col_ff) + EW'(1);
   assign row_p1   = EH'(row_ff) + EH'(1);
   assign last_col = (col_p1 >= w_eff);
   assign last_row = (row_p1 >= h_eff);
   assign emit     = (row_ff >= RB'(bb5_pkg::WIN - 1)) && (col_ff >= CB'(bb5_pkg::WIN - 1));

   // Every item in flight that will emit a mean needs a queue slot, so reserve one for each.
   assign committed = (bb5_pkg::FIFO_CW + 1)'(fifo_status.count)
                    + (bb5_pkg::FIFO_CW + 1)'(s1_emit_ff)
                    + (bb5_pkg::FIFO_CW + 1)'(s2_emit_ff)
                    + (bb5_pkg::FIFO_CW + 1)'(s3_emit_ff)
                    + (bb5_pkg::FIFO_CW + 1)'(s4_emit_ff);
   assign req_tready = (committed < (bb5_pkg::FIFO_CW + 1)'(bb5_pkg::FIFO_DEPTH));
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : RB'(row_p1);
         end else begin
            col_in = CB'(col_p1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
         s2_emit_ff  <= 1'b0;
         s3_emit_ff  <= 1'b0;
         s4_emit_ff  <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
         s1_emit_ff  <= accept && emit;
         s2_emit_ff  <= s1_emit_ff;
         s3_emit_ff  <= s2_emit_ff;
         s4_emit_ff  <= s3_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= col_ff;
         s1_pix_ff  <= req_tdata;
         s1_eof_ff  <= last_col && last_row;
      end
   end

   // Consecutive items always hit different columns, so the write-back of one
   // item never races the read of the next.
   bb5_line_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (CB)
   ) u_line_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (hist_rd),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (hist_wr)
   );

   // Vertical sum of the new column and the shifted history word.
   always_comb begin
      for (int ch = 0; ch < bb5_pkg::CHANNELS; ch++) begin
         new_colsum[ch] = bb5_pkg::COLSUM_W'(s1_pix_ff[ch])
                        + bb5_pkg::COLSUM_W'(hist_rd[0][ch])
                        + bb5_pkg::COLSUM_W'(hist_rd[1][ch])
                        + bb5_pkg::COLSUM_W'(hist_rd[2][ch])
                        + bb5_pkg::COLSUM_W'(hist_rd[3][ch]);
      end
      for (int k = 0; k < bb5_pkg::HIST_ROWS - 1; k++) begin
         hist_wr[k] = hist_rd[k + 1];
      end
      hist_wr[bb5_pkg::HIST_ROWS-1] = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < bb5_pkg::WIN; k++) begin
            col_sums_ff[k] <= '0;
         end
      end else if (s1_valid_ff) begin
         for (int k = 0; k < bb5_pkg::WIN - 1; k++) begin
            col_sums_ff[k] <= col_sums_ff[k + 1];
         end
         col_sums_ff[bb5_pkg::WIN-1] <= new_colsum;
      end
   end

   always_ff @(posedge clock) begin
      s2_eof_ff <= s1_eof_ff;
   end

   // Horizontal sum over the five column sums, with the rounding bias.
   always_comb begin
      for (int ch = 0; ch < bb5_pkg::CHANNELS; ch++) begin
         win_sum[ch] = bb5_pkg::WINSUM_W'(bb5_pkg::ROUND_BIAS)
                     + bb5_pkg::WINSUM_W'(col_sums_ff[0][ch])
                     + bb5_pkg::WINSUM_W'(col_sums_ff[1][ch])
                     + bb5_pkg::WINSUM_W'(col_sums_ff[2][ch])
                     + bb5_pkg::WINSUM_W'(col_sums_ff[3][ch])
                     + bb5_pkg::WINSUM_W'(col_sums_ff[4][ch]);
      end
   end

   always_ff @(posedge clock) begin
      s3_eof_ff <= s2_eof_ff;
      s4_eof_ff <= s3_eof_ff;
      for (int ch = 0; ch < bb5_pkg::CHANNELS; ch++) begin
         s3_sum_ff[ch]  <= win_sum[ch];
         s4_prod_ff[ch] <= bb5_pkg::PROD_W'(s3_sum_ff[ch])
                         * bb5_pkg::PROD_W'(bb5_pkg::RECIP);
      end
   end

   // Division by 25 is the reciprocal product shifted down.
   always_comb begin
      for (int ch = 0; ch < bb5_pkg::CHANNELS; ch++) begin
         push_data.mean[ch] = s4_prod_ff[ch][bb5_pkg::RECIP_SHIFT +: bb5_pkg::PIX_W];
      end
      push_data.eof = s4_eof_ff;
   end

   bb5_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s4_emit_ff),
      .push_data (push_data),
      .pop       (rsp_tready),
      .pop_data  (pop_data),
      .status    (fifo_status)
   );

   assign rsp_tvalid = fifo_status.not_empty;
   assign rsp_tdata  = pop_data.mean;
   assign rsp_tlast  = pop_data.eof;

endmodule

// ----- src/bb5_checker.sv -----
// Port-level checker for the 5x5 box blur, bound to the top level.
`include "assert_macros.svh"

module bb5_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A result waiting on the output keeps its value until the transfer.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Input backpressure only comes from a queue that already holds results.
   `ASSERT_IMPLIES(a_ready_needs_backlog, clock, reset, !req_tready, rsp_tvalid && $past(rsp_tvalid))

   // A result appearing on an empty output stems from a pixel that just went through s1 to s4 into the queue.
   `ASSERT_IMPLIES(a_rsp_latency, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 5))

   // Nothing is offered on the output right after reset.
   `ASSERT_IMPLIES(a_reset_empty, clock, 1'b0, !reset && $past(reset), !rsp_tvalid)

endmodule

bind box_blur_5x5_rgb bb5_checker u_bb5_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ----- bench/blur_checker.sv -----
// Checker for the 5x5 box blur: predicts each window mean and compares the result stream.
`timescale 1ns / 100ps

module blur_checker #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [23:0]               req_tdata,   // pixel_blue, pixel_green, pixel_red
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [23:0]               rsp_tdata,   // mean_blue, mean_green, mean_red
   input  logic                      rsp_tlast,
   input  logic                      csr_we,
   input  logic [0:0]                csr_index,
   input  logic [bb5_pkg::CSR_W-1:0] csr_wdata,
   output int                        mismatches,
   output int                        means_pending,
   output int                        means_checked
);

   // Previous four rows per column; entry [HIST_ROWS-1] is the newest row.
   bb5_pkg::rgb_type    line_rows [MAX_WIDTH][bb5_pkg::HIST_ROWS];
   int                  col_sum [bb5_pkg::WIN][bb5_pkg::CHANNELS];
   int                  at_col;
   int                  at_row;
   logic [bb5_pkg::FW_BITS-1:0] width_reg;
   logic [bb5_pkg::FH_BITS-1:0] height_reg;
   bb5_pkg::result_type means_due [$];
   int                  fail_count;
   int                  seen_count;
   string               chan_name [bb5_pkg::CHANNELS] = '{"blue", "green", "red"};

   function automatic int fit_size(int v, int hi);
      if (v < bb5_pkg::MIN_SIZE) return bb5_pkg::MIN_SIZE;
      if (v > hi) return hi;
      return v;
   endfunction

   // Take one pixel into the window and queue the mean it completes, if any.
   task automatic blur_pixel(input bb5_pkg::rgb_type px);
      int w;
      int h;
      int c;
      int r;
      int s;
      bb5_pkg::result_type m;
      w = fit_size(int'(width_reg), MAX_WIDTH);
      h = fit_size(int'(height_reg), MAX_HEIGHT);
      c = (at_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : at_col;
      r = at_row;
      for (int k = 0; k < bb5_pkg::WIN - 1; k++) begin
         col_sum[k] = col_sum[k + 1];
      end
      for (int ch = 0; ch < bb5_pkg::CHANNELS; ch++) begin
         s = int'(px[ch]);
         for (int k = 0; k < bb5_pkg::HIST_ROWS; k++) begin
            s += int'(line_rows[c][k][ch]);
         end
         col_sum[bb5_pkg::WIN - 1][ch] = s;
      end
      if (r >= bb5_pkg::WIN - 1 && c >= bb5_pkg::WIN - 1) begin
         for (int ch = 0; ch < bb5_pkg::CHANNELS; ch++) begin
            s = 0;
            for (int k = 0; k < bb5_pkg::WIN; k++) begin
               s += col_sum[k][ch];
            end
            m.mean[ch] = bb5_pkg::chan_type'((s + bb5_pkg::ROUND_BIAS)
                                             / (bb5_pkg::WIN * bb5_pkg::WIN));
         end
         m.eof = (r + 1 >= h) && (c + 1 >= w);
         means_due.push_back(m);
      end
      for (int k = 0; k < bb5_pkg::HIST_ROWS - 1; k++) begin
         line_rows[c][k] = line_rows[c][k + 1];
      end
      line_rows[c][bb5_pkg::HIST_ROWS - 1] = px;
      if (c + 1 >= w) begin
         at_col = 0;
         at_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         at_col = c + 1;
         at_row = r;
      end
   endtask

   always @(posedge clock) begin
      bb5_pkg::result_type got;
      bb5_pkg::result_type want;
      bit                  bad;
      if (reset) begin
         width_reg  = bb5_pkg::FW_BITS'(bb5_pkg::FW_RESET);
         height_reg = bb5_pkg::FH_BITS'(bb5_pkg::FH_RESET);
         at_col     = 0;
         at_row     = 0;
         for (int k = 0; k < bb5_pkg::WIN; k++) begin
            for (int ch = 0; ch < bb5_pkg::CHANNELS; ch++) begin
               col_sum[k][ch] = 0;
            end
         end
         means_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               bb5_pkg::REG_FRAME_WIDTH: begin
                  width_reg = csr_wdata[bb5_pkg::FW_BITS-1:0];
               end
               bb5_pkg::REG_FRAME_HEIGHT: begin
                  height_reg = csr_wdata[bb5_pkg::FH_BITS-1:0];
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            blur_pixel(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.mean = rsp_tdata;
            got.eof  = rsp_tlast;
            if (means_due.size() == 0) begin
               $display("%0t: result with none expected: data %h tlast %b",
                        $time, rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               want = means_due.pop_front();
               seen_count++;
               bad  = 1'b0;
               for (int ch = 0; ch < bb5_pkg::CHANNELS; ch++) begin
                  if (got.mean[ch] !== want.mean[ch]) begin
                     $display("%0t: mean_%s expected %0d, got %0d", $time,
                              chan_name[ch], want.mean[ch], got.mean[ch]);
                     bad = 1'b1;
                  end
               end
               if (got.eof !== want.eof) begin
                  $display("%0t: end_of_frame expected %b, got %b", $time,
                           want.eof, got.eof);
                  bad = 1'b1;
               end
               if (bad) fail_count++;
            end
         end
      end
      mismatches    <= fail_count;
      means_pending <= means_due.size();
      means_checked <= seen_count;
   end

endmodule

// ----- bench/tb.sv -----
// Top of the box blur testbench: clock, reset, pixel frames, register writes and verdict.
`timescale 1ns / 100ps

module tb;

   localparam int MAX_W = 2048;
   localparam int MAX_H = 4096;

   typedef enum int {PX_RANDOM, PX_WHITE, PX_BLACK} fill_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [23:0]               req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [23:0]               rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_we;
   logic [0:0]                csr_index;
   logic [bb5_pkg::CSR_W-1:0] csr_wdata;

   int mismatches;
   int means_pending;
   int means_checked;

   // Stimulus bookkeeping: where the next pixel lands and the sizes in force.
   bit calm;
   int eff_w;
   int eff_h;
   int col_at;
   int row_at;
   int pixels_sent;
   int frames_done;

   box_blur_5x5_rgb #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   blur_checker #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .means_pending (means_pending),
      .means_checked (means_checked)
   );

   initial clock = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int draw_gap();
      return calm ? 0 : int'($urandom_range(9, 0));
   endfunction

   function automatic int fit(int v, int hi);
      if (v < bb5_pkg::MIN_SIZE) return bb5_pkg::MIN_SIZE;
      if (v > hi) return hi;
      return v;
   endfunction

   // Drops valid and holds off until every queued mean has come out.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (means_pending != 0);
      repeat (8) @(posedge clock);
   endtask

   // Both registers are written back to back so the write enable stays high.
   task automatic set_size(int w, int h);
      csr_we    <= 1'b1;
      csr_index <= bb5_pkg::REG_FRAME_WIDTH;
      csr_wdata <= bb5_pkg::CSR_W'(w);
      @(posedge clock);
      csr_index <= bb5_pkg::REG_FRAME_HEIGHT;
      csr_wdata <= bb5_pkg::CSR_W'(h);
      @(posedge clock);
      csr_we    <= 1'b0;
      eff_w = fit(w & 'hFFF, MAX_W);
      eff_h = fit(h & 'h1FFF, MAX_H);
   endtask

   task automatic send_pixel(fill_type kind);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      case (kind)
         PX_WHITE: req_tdata <= '1;
         PX_BLACK: req_tdata <= '0;
         default:  req_tdata <= 24'($urandom);
      endcase
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      if (col_at + 1 >= eff_w) begin
         col_at = 0;
         row_at = (row_at + 1 >= eff_h) ? 0 : row_at + 1;
      end else begin
         col_at++;
      end
   endtask

   // Sends pixels until the current frame wraps back to its first position.
   task automatic finish_frame(fill_type kind);
      do send_pixel(kind); while (col_at != 0 || row_at != 0);
      frames_done++;
   endtask

   // Mostly small widths, now and then one below the minimum or with the unused bit set.
   function automatic int pick_width();
      int roll;
      roll = $urandom_range(15, 0);
      if (roll == 0) return $urandom_range(4, 0);
      if (roll == 1) return 4096 + $urandom_range(12, 5);
      return $urandom_range(12, 5);
   endfunction

   function automatic int pick_height();
      if ($urandom_range(15, 0) == 0) return $urandom_range(4, 0);
      return $urandom_range(9, 5);
   endfunction

   // Result side: each transfer is preceded by a random stall.
   initial begin : drain
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      #20_000_000;
      $display("timeout at %0t with %0d means still owed", $time, means_pending);
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int random_start;
      int cut;
      int waited;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = bb5_pkg::REG_FRAME_WIDTH;
      csr_wdata  = '0;
      calm       = 1'b0;
      col_at     = 0;
      row_at     = 0;
      eff_w      = bb5_pkg::FW_RESET;
      eff_h      = bb5_pkg::FH_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sizes below the minimum act as 5x5: one mean per frame, saturated, zero and random.
      set_size(0, 3);
      finish_frame(PX_WHITE);
      finish_frame(PX_BLACK);
      finish_frame(PX_RANDOM);

      // Shrink both sizes mid-frame to below the current position: the very
      // next pixel closes the row and the frame.
      wait_idle();
      set_size(9, 8191);
      repeat (6 * 9 + 7) send_pixel(PX_RANDOM);
      wait_idle();
      set_size(5, 5);
      send_pixel(PX_RANDOM);
      frames_done++;

      random_start = pixels_sent;
      while (pixels_sent - random_start < 760) begin
         calm = ($urandom_range(3, 0) == 0);
         if ($urandom_range(1, 0) == 1) begin
            wait_idle();
            set_size(pick_width(), pick_height());
         end
         if ($urandom_range(7, 0) == 0) begin
            // Break into a frame and narrow it; widening mid-frame would
            // read line entries that were never written.
            cut = $urandom_range(eff_w * eff_h - 1, 1);
            repeat (cut) send_pixel(PX_RANDOM);
            wait_idle();
            set_size($urandom_range(eff_w, 0), $urandom_range(12, 0));
         end
         finish_frame(PX_RANDOM);
      end
      calm = 1'b0;

      req_tvalid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (means_pending != 0 && waited < 200000);
      repeat (10) @(posedge clock);

      $display("Sent %0d pixels in %0d frames, sizes 5x5 up to 12 wide, with size changes",
               pixels_sent, frames_done);
      $display("inside frames; %0d window means checked, %0d never arrived.",
               means_checked, means_pending);
      if (mismatches == 0 && means_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- box_blur_5x5_rgb.f -----
+incdir+src
src/bb5_pkg.sv
src/bb5_line_ram.sv
src/bb5_out_fifo.sv
src/box_blur_5x5_rgb.sv
src/bb5_checker.sv
bench/blur_checker.sv
bench/tb.sv
